/* hdl/bresenham_line_pixel_generator_defines.svh */
// Assertion macros used by the checker file blpg_checker.sv.
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_DEFINES_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define BLPG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("blpg assertion failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define BLPG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("blpg assertion failed");

`endif

/* hdl/blpg_pkg.sv */
`default_nettype none

package blpg_pkg;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    localparam logic [1:0] LINE_VERT    = 2'd0;
    localparam logic [1:0] LINE_SHALLOW = 2'd1;
    localparam logic [1:0] LINE_STEEP   = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic       mirrored;
    } line_ctrl_t;

endpackage

`default_nettype wire

/* hdl/blpg_setup.sv */
`default_nettype none

module blpg_setup import blpg_pkg::*; #(
    parameter int CW = 16
) (
    input  wire logic signed [CW-1:0] x_start,
    input  wire logic signed [CW-1:0] y_start,
    input  wire logic signed [CW-1:0] x_end,
    input  wire logic signed [CW-1:0] y_end,
    output line_ctrl_t                ctrl,
    output logic signed [CW-1:0]      cur_col,
    output logic signed [CW-1:0]      end_col,
    output logic signed [CW-1:0]      origin_row,
    output logic signed [CW+1:0]      cur_row,
    output logic signed [CW+1:0]      end_row,
    output logic signed [CW+2:0]      err,
    output logic signed [CW+2:0]      step_s,
    output logic signed [CW+2:0]      step_d
);

    logic                swap;
    logic                vert;
    logic                shallow;
    logic signed [CW-1:0] x1, y1, x2, y2, ylo, yhi;
    logic signed [CW:0]   dx, dy_raw, dy_abs;
    logic signed [CW+2:0] dx_w, dy_w, major_w, minor_w;

    // order endpoints so the column rises
    assign swap = x_start > x_end;
    assign x1   = swap ? x_end   : x_start;
    assign y1   = swap ? y_end   : y_start;
    assign x2   = swap ? x_start : x_end;
    assign y2   = swap ? y_start : y_end;
    assign vert = (x1 == x2);

    assign ylo = (y1 > y2) ? y2 : y1;
    assign yhi = (y1 > y2) ? y1 : y2;

    assign dx      = {x2[CW-1], x2} - {x1[CW-1], x1};
    assign dy_raw  = {y2[CW-1], y2} - {y1[CW-1], y1};
    assign dy_abs  = dy_raw[CW] ? -dy_raw : dy_raw;
    assign shallow = dx >= dy_abs;

    assign dx_w    = {{2{dx[CW]}}, dx};
    assign dy_w    = {{2{dy_abs[CW]}}, dy_abs};
    assign major_w = shallow ? dx_w : dy_w;
    assign minor_w = shallow ? dy_w : dx_w;

    assign step_s = vert ? '0 : (minor_w + minor_w);
    assign step_d = vert ? '0 : (step_s - major_w - major_w);
    assign err    = vert ? '0 : (step_s - major_w);

    assign ctrl.mode     = vert ? LINE_VERT : (shallow ? LINE_SHALLOW : LINE_STEEP);
    assign ctrl.mirrored = !vert && dy_raw[CW];

    assign cur_col    = x1;
    assign end_col    = x2;
    assign origin_row = vert ? ylo : y1;
    assign cur_row    = {{2{origin_row[CW-1]}}, origin_row};
    assign end_row    = vert ? {{2{yhi[CW-1]}}, yhi}
                             : ({{2{y1[CW-1]}}, y1} + {dy_abs[CW], dy_abs});

endmodule

`default_nettype wire

/* hdl/blpg_step.sv */
`default_nettype none

module blpg_step import blpg_pkg::*; #(
    parameter int CW = 16
) (
    input  wire line_ctrl_t           ctrl,
    input  wire logic signed [CW-1:0] cur_col,
    input  wire logic signed [CW+1:0] cur_row,
    input  wire logic signed [CW+2:0] err,
    input  wire logic signed [CW+2:0] step_s,
    input  wire logic signed [CW+2:0] step_d,
    output logic signed [CW-1:0]      nxt_col,
    output logic signed [CW+1:0]      nxt_row,
    output logic signed [CW+2:0]      nxt_err
);

    always_comb begin
        nxt_col = cur_col;
        nxt_row = cur_row;
        nxt_err = err;
        case (ctrl.mode)
            LINE_VERT: begin
                nxt_row = cur_row + (CW+2)'(1);
            end
            LINE_SHALLOW, LINE_STEEP: begin
                if (err[CW+2]) begin
                    nxt_err = err + step_s;
                    if (ctrl.mode == LINE_SHALLOW) begin
                        nxt_col = cur_col + CW'(1);
                    end else begin
                        nxt_row = cur_row + (CW+2)'(1);
                    end
                end else begin
                    nxt_err = err + step_d;
                    nxt_col = cur_col + CW'(1);
                    nxt_row = cur_row + (CW+2)'(1);
                end
            end
            default: begin
                nxt_col = cur_col;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/bresenham_line_pixel_generator.sv */
// Each accepted input item passes through the input register and then the result register.
// Throughput: one item per cycle unless m_ready stalls; each advance is one error add, one step and an end compare.
// Stalls on m_ready back up through the result register to s_ready without losing items.
// Reset (aresetn low, synchronous): no line active, input and result registers empty.
`default_nettype none

module bresenham_line_pixel_generator import blpg_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int COLOR_BITS = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_command,
    input  wire logic signed [COORD_BITS-1:0] s_x_start,
    input  wire logic signed [COORD_BITS-1:0] s_y_start,
    input  wire logic signed [COORD_BITS-1:0] s_x_end,
    input  wire logic signed [COORD_BITS-1:0] s_y_end,
    input  wire logic [COLOR_BITS-1:0]        s_line_color,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_valid_res,
    output logic signed [COORD_BITS-1:0]      m_pixel_x,
    output logic signed [COORD_BITS-1:0]      m_pixel_y,
    output logic [COLOR_BITS-1:0]             m_pixel_color,
    output logic                              m_last
);

    localparam int CW = COORD_BITS;

    // input register
    logic                 in_vld_reg, in_vld_next;
    logic                 cmd_reg;
    logic signed [CW-1:0] xs_reg, ys_reg, xe_reg, ye_reg;
    logic [COLOR_BITS-1:0] color_in_reg;

    // line state
    logic                  active_reg, active_next;
    line_ctrl_t            ctrl_reg, ctrl_next;
    logic signed [CW-1:0]  col_reg, col_next;
    logic signed [CW+1:0]  row_reg, row_next;
    logic signed [CW-1:0]  end_col_reg, end_col_next;
    logic signed [CW+1:0]  end_row_reg, end_row_next;
    logic signed [CW-1:0]  origin_reg, origin_next;
    logic signed [CW+2:0]  err_reg, err_next;
    logic signed [CW+2:0]  st_s_reg, st_s_next;
    logic signed [CW+2:0]  st_d_reg, st_d_next;
    logic [COLOR_BITS-1:0] color_reg, color_next;

    // result register
    logic                  out_vld_reg, out_vld_next;
    logic                  res_reg, res_next;
    logic signed [CW-1:0]  px_reg, px_next;
    logic signed [CW-1:0]  py_reg, py_next;
    logic [COLOR_BITS-1:0] pc_reg, pc_next;
    logic                  last_reg, last_next;

    logic adv;
    logic fire;
    logic fin;
    logic signed [CW+1:0] row_out;

    line_ctrl_t            su_ctrl;
    logic signed [CW-1:0]  su_col, su_end_col, su_origin;
    logic signed [CW+1:0]  su_row, su_end_row;
    logic signed [CW+2:0]  su_err, su_st_s, su_st_d;
    logic signed [CW-1:0]  sp_col;
    logic signed [CW+1:0]  sp_row;
    logic signed [CW+2:0]  sp_err;

    assign adv     = !out_vld_reg || m_ready;
    assign fire    = in_vld_reg && adv;
    assign s_ready = !in_vld_reg || adv;

    blpg_setup #(.CW(CW)) u_setup (
        .x_start    (xs_reg),
        .y_start    (ys_reg),
        .x_end      (xe_reg),
        .y_end      (ye_reg),
        .ctrl       (su_ctrl),
        .cur_col    (su_col),
        .end_col    (su_end_col),
        .origin_row (su_origin),
        .cur_row    (su_row),
        .end_row    (su_end_row),
        .err        (su_err),
        .step_s     (su_st_s),
        .step_d     (su_st_d)
    );

    blpg_step #(.CW(CW)) u_step (
        .ctrl    (ctrl_reg),
        .cur_col (col_reg),
        .cur_row (row_reg),
        .err     (err_reg),
        .step_s  (st_s_reg),
        .step_d  (st_d_reg),
        .nxt_col (sp_col),
        .nxt_row (sp_row),
        .nxt_err (sp_err)
    );

    always_comb begin
        if (cmd_reg == CMD_START) begin
            ctrl_next    = su_ctrl;
            col_next     = su_col;
            row_next     = su_row;
            end_col_next = su_end_col;
            end_row_next = su_end_row;
            origin_next  = su_origin;
            err_next     = su_err;
            st_s_next    = su_st_s;
            st_d_next    = su_st_d;
            color_next   = color_in_reg;
        end else begin
            ctrl_next    = ctrl_reg;
            col_next     = sp_col;
            row_next     = sp_row;
            end_col_next = end_col_reg;
            end_row_next = end_row_reg;
            origin_next  = origin_reg;
            err_next     = sp_err;
            st_s_next    = st_s_reg;
            st_d_next    = st_d_reg;
            color_next   = color_reg;
        end
    end

    assign fin     = (col_next >= end_col_next) && (row_next >= end_row_next);
    assign row_out = ctrl_next.mirrored
                   ? ({origin_next[CW-1], origin_next, 1'b0} - row_next) : row_next;

    always_comb begin
        in_vld_next  = in_vld_reg;
        out_vld_next = out_vld_reg;
        active_next  = active_reg;
        res_next     = res_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        pc_next      = pc_reg;
        last_next    = last_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (adv) begin
            in_vld_next = 1'b0;
        end
        if (fire) begin
            out_vld_next = 1'b1;
            if (cmd_reg == CMD_START || active_reg) begin
                active_next = !fin;
                res_next    = 1'b1;
                px_next     = col_next;
                py_next     = row_out[CW-1:0];
                pc_next     = color_next;
                last_next   = fin;
            end else begin
                res_next  = 1'b0;
                px_next   = '0;
                py_next   = '0;
                pc_next   = '0;
                last_next = 1'b0;
            end
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            active_reg  <= 1'b0;
            ctrl_reg    <= '0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (fire && (cmd_reg == CMD_START || active_reg)) begin
                active_reg <= active_next;
                ctrl_reg   <= ctrl_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg      <= s_command;
            xs_reg       <= s_x_start;
            ys_reg       <= s_y_start;
            xe_reg       <= s_x_end;
            ye_reg       <= s_y_end;
            color_in_reg <= s_line_color;
        end
        if (fire && (cmd_reg == CMD_START || active_reg)) begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            end_col_reg <= end_col_next;
            end_row_reg <= end_row_next;
            origin_reg  <= origin_next;
            err_reg     <= err_next;
            st_s_reg    <= st_s_next;
            st_d_reg    <= st_d_next;
            color_reg   <= color_next;
        end
        res_reg  <= res_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        pc_reg   <= pc_next;
        last_reg <= last_next;
    end

    assign m_valid       = out_vld_reg;
    assign m_valid_res   = res_reg;
    assign m_pixel_x     = px_reg;
    assign m_pixel_y     = py_reg;
    assign m_pixel_color = pc_reg;
    assign m_last        = last_reg;

endmodule

`default_nettype wire

/* hdl/blpg_checker.sv */
`default_nettype none

`include "bresenham_line_pixel_generator_defines.svh"

module blpg_checker #(
    parameter int COORD_BITS = 16,
    parameter int COLOR_BITS = 32
) (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic                         m_valid_res,
    input wire logic signed [COORD_BITS-1:0] m_pixel_x,
    input wire logic signed [COORD_BITS-1:0] m_pixel_y,
    input wire logic [COLOR_BITS-1:0]        m_pixel_color,
    input wire logic                         m_last
);

    `BLPG_ASSERT_IMP(a_idle_zero, m_valid && !m_valid_res,
        m_pixel_x == '0 && m_pixel_y == '0 && m_pixel_color == '0 && !m_last)

    `BLPG_ASSERT_IMP(a_last_is_pixel, m_valid && m_last, m_valid_res)

    `BLPG_ASSERT_NXT(a_out_hold, m_valid && !m_ready,
        m_valid && $stable(m_pixel_x) && $stable(m_pixel_y) && $stable(m_last))

endmodule

bind bresenham_line_pixel_generator blpg_checker #(
    .COORD_BITS(COORD_BITS),
    .COLOR_BITS(COLOR_BITS)
) u_blpg_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench import blpg_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W = 16;
    localparam int COLOR_W = 32;
    localparam int RANDOM_ITEMS = 550;
    localparam int HOLD_OFF_CYCLES = 80;

    typedef struct packed {
        logic                      valid_res;
        logic signed [COORD_W-1:0] pixel_x;
        logic signed [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0]        pixel_color;
        logic                      last;
    } pixel_t;

    class line_trace_board;
        logic                      active;
        logic [1:0]                mode;
        logic                      mirror;
        logic signed [COORD_W-1:0] col;
        logic signed [COORD_W+1:0] row;
        logic signed [COORD_W-1:0] end_col;
        logic signed [COORD_W+1:0] end_row;
        logic signed [COORD_W-1:0] origin;
        logic signed [COORD_W+2:0] err;
        logic signed [COORD_W+1:0] straight;
        logic signed [COORD_W+2:0] diag;
        logic [COLOR_W-1:0]        color;
        pixel_t                    pixel_q[$];
        int                        errors;
        int                        compared;
        int                        lines_started;
        int                        lines_finished;

        function new();
            active = 1'b0;
            mode = LINE_VERT;
            mirror = 1'b0;
            col = '0;
            row = '0;
            end_col = '0;
            end_row = '0;
            origin = '0;
            err = '0;
            straight = '0;
            diag = '0;
            color = '0;
            errors = 0;
            compared = 0;
            lines_started = 0;
            lines_finished = 0;
        endfunction

        function pixel_t pixel_here();
            pixel_t px;
            int     r;
            r = mirror ? (2 * origin - row) : row;
            px.valid_res = 1'b1;
            px.pixel_x = col;
            px.pixel_y = COORD_W'(r);
            px.pixel_color = color;
            px.last = (col >= end_col) && (row >= end_row);
            if (px.last) begin
                active = 1'b0;
            end
            return px;
        endfunction

        function void trace_item(logic cmd, logic signed [COORD_W-1:0] xs,
                                 logic signed [COORD_W-1:0] ys,
                                 logic signed [COORD_W-1:0] xe,
                                 logic signed [COORD_W-1:0] ye,
                                 logic [COLOR_W-1:0] c);
            pixel_t px;
            int     x1, y1, x2, y2, t, dx, dy;
            if (cmd == CMD_START) begin
                x1 = int'(xs);
                y1 = int'(ys);
                x2 = int'(xe);
                y2 = int'(ye);
                color = c;
                lines_started++;
                if (x1 > x2) begin
                    t = x1; x1 = x2; x2 = t;
                    t = y1; y1 = y2; y2 = t;
                end
                mirror = 1'b0;
                err = '0;
                straight = '0;
                diag = '0;
                if (x1 == x2) begin
                    if (y1 > y2) begin
                        t = y1; y1 = y2; y2 = t;
                    end
                    mode = LINE_VERT;
                    origin = COORD_W'(y1);
                end else begin
                    dx = x2 - x1;
                    dy = y2 - y1;
                    origin = COORD_W'(y1);
                    if (dy < 0) begin
                        mirror = 1'b1;
                        dy = -dy;
                        y2 = y1 + dy;
                    end
                    if (dx >= dy) begin
                        mode = LINE_SHALLOW;
                        straight = (COORD_W+2)'(2 * dy);
                        diag = (COORD_W+3)'(2 * dy - 2 * dx);
                        err = (COORD_W+3)'(2 * dy - dx);
                    end else begin
                        mode = LINE_STEEP;
                        straight = (COORD_W+2)'(2 * dx);
                        diag = (COORD_W+3)'(2 * dx - 2 * dy);
                        err = (COORD_W+3)'(2 * dx - dy);
                    end
                end
                col = COORD_W'(x1);
                row = (COORD_W+2)'(y1);
                end_col = COORD_W'(x2);
                end_row = (COORD_W+2)'(y2);
                active = 1'b1;
                px = pixel_here();
            end else if (!active) begin
                px = '0;
            end else begin
                if (mode == LINE_VERT) begin
                    row = row + (COORD_W+2)'(1);
                end else if (err < 0) begin
                    err = err + (COORD_W+3)'(straight);
                    if (mode == LINE_SHALLOW) begin
                        col = col + COORD_W'(1);
                    end else begin
                        row = row + (COORD_W+2)'(1);
                    end
                end else begin
                    err = err + diag;
                    col = col + COORD_W'(1);
                    row = row + (COORD_W+2)'(1);
                end
                px = pixel_here();
            end
            pixel_q.push_back(px);
        endfunction

        function void check_pixel(logic vr, logic signed [COORD_W-1:0] x,
                                  logic signed [COORD_W-1:0] y,
                                  logic [COLOR_W-1:0] c, logic l);
            pixel_t want;
            if (pixel_q.size() == 0) begin
                $error("result with no item pending: x=%0d y=%0d", x, y);
                errors++;
                return;
            end
            want = pixel_q.pop_front();
            compared++;
            if (l && vr) begin
                lines_finished++;
            end
            if (vr !== want.valid_res) begin
                $error("valid_res mismatch: expected %0d, got %0d", want.valid_res, vr);
                errors++;
            end
            if (x !== want.pixel_x) begin
                $error("pixel_x mismatch: expected %0d, got %0d", want.pixel_x, x);
                errors++;
            end
            if (y !== want.pixel_y) begin
                $error("pixel_y mismatch: expected %0d, got %0d", want.pixel_y, y);
                errors++;
            end
            if (c !== want.pixel_color) begin
                $error("pixel_color mismatch: expected %h, got %h", want.pixel_color, c);
                errors++;
            end
            if (l !== want.last) begin
                $error("last mismatch: expected %0d, got %0d", want.last, l);
                errors++;
            end
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic s_command;
    logic signed [COORD_W-1:0] s_x_start;
    logic signed [COORD_W-1:0] s_y_start;
    logic signed [COORD_W-1:0] s_x_end;
    logic signed [COORD_W-1:0] s_y_end;
    logic [COLOR_W-1:0] s_line_color;
    logic m_valid;
    logic m_ready;
    logic m_valid_res;
    logic signed [COORD_W-1:0] m_pixel_x;
    logic signed [COORD_W-1:0] m_pixel_y;
    logic [COLOR_W-1:0] m_pixel_color;
    logic m_last;

    line_trace_board board;
    int src_idle_pct;
    int sink_idle_pct;
    int items_sent;
    bit hold_off_req;
    int hold_left;

    bresenham_line_pixel_generator #(
        .COORD_BITS(COORD_W),
        .COLOR_BITS(COLOR_W)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_x_start(s_x_start),
        .s_y_start(s_y_start),
        .s_x_end(s_x_end),
        .s_y_end(s_y_end),
        .s_line_color(s_line_color),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_valid_res(m_valid_res),
        .m_pixel_x(m_pixel_x),
        .m_pixel_y(m_pixel_y),
        .m_pixel_color(m_pixel_color),
        .m_last(m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                board.trace_item(s_command, s_x_start, s_y_start, s_x_end, s_y_end,
                                 s_line_color);
            end
            if (m_valid && m_ready) begin
                board.check_pixel(m_valid_res, m_pixel_x, m_pixel_y, m_pixel_color, m_last);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = HOLD_OFF_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    task automatic send_item(logic cmd, int xs, int ys, int xe, int ye, logic [COLOR_W-1:0] c);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_x_start <= COORD_W'(xs);
        s_y_start <= COORD_W'(ys);
        s_x_end <= COORD_W'(xe);
        s_y_end <= COORD_W'(ye);
        s_line_color <= c;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        items_sent++;
    endtask

    task automatic advance_line(int count);
        repeat (count) begin
            send_item(CMD_ADVANCE, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic random_line();
        int xs, ys, xe, ye, dx, dy, steps, adv, pick, tail;
        pick = $urandom_range(0, 19);
        xs = int'($urandom_range(0, 65535)) - 32768;
        ys = int'($urandom_range(0, 65535)) - 32768;
        if (pick == 0) begin
            xe = int'($urandom_range(0, 65535)) - 32768;
            ye = int'($urandom_range(0, 65535)) - 32768;
        end else begin
            dx = int'($urandom_range(0, 32)) - 16;
            dy = int'($urandom_range(0, 32)) - 16;
            if (pick == 1) begin
                dx = 0;
            end else if (pick == 2) begin
                dy = 0;
            end else if (pick == 3) begin
                dy = $urandom_range(0, 1) ? dx : -dx;
            end else if (pick == 4) begin
                dx = 0;
                dy = 0;
            end
            xe = xs + dx;
            if (xe > 32767 || xe < -32768) begin
                xe = xs - dx;
            end
            ye = ys + dy;
            if (ye > 32767 || ye < -32768) begin
                ye = ys - dy;
            end
        end
        dx = (xe > xs) ? xe - xs : xs - xe;
        dy = (ye > ys) ? ye - ys : ys - ye;
        steps = (dx > dy) ? dx : dy;
        tail = $urandom_range(0, 9);
        if (pick == 0) begin
            adv = $urandom_range(0, 12);
        end else if (tail == 0) begin
            adv = $urandom_range(0, steps);
        end else if (tail == 1) begin
            adv = steps + $urandom_range(1, 2);
        end else begin
            adv = steps;
        end
        send_item(CMD_START, xs, ys, xe, ye, $urandom);
        advance_line(adv);
    endtask

    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int random_goal;
        board = new();
        src_idle_pct = 16;
        sink_idle_pct = 83;
        items_sent = 0;
        hold_off_req = 1'b0;
        hold_left = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_command <= CMD_START;
        s_x_start <= '0;
        s_y_start <= '0;
        s_x_end <= '0;
        s_y_end <= '0;
        s_line_color <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        advance_line(1);
        send_item(CMD_START, -32768, 32767, -32768, 32767, 32'hFFFF_FFFF);
        advance_line(1);
        send_item(CMD_START, 2, -2, -1, -2, 32'h1234_5678);
        advance_line(3);
        send_item(CMD_START, 7, 5, 7, 2, 32'h00FF_00FF);
        advance_line(3);
        send_item(CMD_START, 0, 0, 2, 2, 32'hA5A5_5A5A);
        advance_line(2);
        send_item(CMD_START, 8, 0, 10, -5, 32'h8000_0001);
        advance_line(5);
        send_item(CMD_START, 0, 3, 4, 1, 32'h0F0F_F0F0);
        advance_line(1);
        send_item(CMD_START, -32768, 32767, 32767, -32768, 32'h0000_0000);
        advance_line(2);

        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal) begin
            if (items_sent >= random_goal - RANDOM_ITEMS / 3 && sink_idle_pct != 0) begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
                hold_off_req = 1'b1;
            end else if (items_sent >= random_goal - 2 * RANDOM_ITEMS / 3
                         && src_idle_pct == 16) begin
                src_idle_pct = 83;
                sink_idle_pct = 16;
            end
            if ($urandom_range(0, 9) == 0) begin
                advance_line(1);
            end else begin
                random_line();
            end
        end
        s_valid <= 1'b0;

        while (board.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        $display("Sent %0d items: %0d lines started, %0d traced to their last pixel.",
                 items_sent, board.lines_started, board.lines_finished);
        $display("Compared %0d results field by field, %0d mismatches.",
                 board.compared, board.errors);
        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
